@@ rtl/assert_macros.svh @@
// shared assertion macros for the frame parser checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gfp assertion failed");

// next-cycle implication
`define GFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gfp assertion failed");

`endif

@@ rtl/gfp_pkg.sv @@
package gfp_pkg;

    localparam int PAYLOAD_MAX_DEF = 28;

    // payload bytes that feed the controller state
    localparam int UNPACK_BYTES = 28;
    localparam int PAYLOAD_BITS = UNPACK_BYTES * 8;
    localparam int SIDX_W       = $clog2(UNPACK_BYTES);

    localparam int QUEUE_DEPTH  = 2;

    localparam int CFG_INDEX_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_FIRST    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_SECOND   = 8'd3;

    localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
    localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
    localparam logic [7:0] TAIL_FIRST_RST    = 8'd85;
    localparam logic [7:0] TAIL_SECOND_RST   = 8'd170;

    typedef enum logic [3:0] {
        PH_HEAD0,
        PH_HEAD1,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CHK0,
        PH_CHK1,
        PH_TAIL0,
        PH_TAIL1
    } phase_t;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
    } cfg_t;

    // one completed frame on its way to the back end
    typedef struct packed {
        logic [7:0]              id;
        logic [15:0]             check;
        logic                    dec;
        logic [PAYLOAD_BITS-1:0] payload;
    } rec_t;

endpackage

@@ rtl/gfp_front.sv @@
module gfp_front #(
    parameter int PAYLOAD_MAX = gfp_pkg::PAYLOAD_MAX_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gfp_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          q_full,
    output logic          push,
    output gfp_pkg::rec_t push_rec
);

    localparam int IDX_W = $clog2(PAYLOAD_MAX + 1);

    gfp_pkg::phase_t phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] len_reg, len_next;
    logic [7:0]       id_reg, id_next;
    logic [15:0]      check_reg, check_next;
    logic [7:0]       stage_reg [gfp_pkg::UNPACK_BYTES];
    logic             in_fire;
    logic             stage_we;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;
    assign idx_inc  = idx_reg + 1'b1;
    assign stage_we = in_fire && (phase_reg == gfp_pkg::PH_DATA)
                      && (idx_reg < IDX_W'(gfp_pkg::UNPACK_BYTES));

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        id_next    = id_reg;
        check_next = check_reg;
        push       = 1'b0;
        if (in_fire)
        begin
            unique case (phase_reg)
                gfp_pkg::PH_HEAD0:
                begin
                    if (in_byte == cfg.header_first)
                        phase_next = gfp_pkg::PH_HEAD1;
                end
                gfp_pkg::PH_HEAD1:
                begin
                    phase_next = (in_byte == cfg.header_second) ? gfp_pkg::PH_ID
                                                               : gfp_pkg::PH_HEAD0;
                end
                gfp_pkg::PH_ID:
                begin
                    id_next    = in_byte;
                    phase_next = gfp_pkg::PH_LEN;
                end
                gfp_pkg::PH_LEN:
                begin
                    // oversize length drops the frame
                    if (in_byte > 8'(PAYLOAD_MAX))
                    begin
                        phase_next = gfp_pkg::PH_HEAD0;
                    end
                    else
                    begin
                        len_next   = in_byte[IDX_W-1:0];
                        idx_next   = '0;
                        phase_next = gfp_pkg::PH_DATA;
                    end
                end
                gfp_pkg::PH_DATA:
                begin
                    // zero length still eats one byte
                    idx_next = idx_inc;
                    if (idx_inc >= len_reg)
                        phase_next = gfp_pkg::PH_CHK0;
                end
                gfp_pkg::PH_CHK0:
                begin
                    check_next = {in_byte, check_reg[7:0]};
                    phase_next = gfp_pkg::PH_CHK1;
                end
                gfp_pkg::PH_CHK1:
                begin
                    check_next = {check_reg[15:8], in_byte};
                    phase_next = gfp_pkg::PH_TAIL0;
                end
                gfp_pkg::PH_TAIL0:
                begin
                    phase_next = (in_byte == cfg.tail_first) ? gfp_pkg::PH_TAIL1
                                                            : gfp_pkg::PH_HEAD0;
                end
                gfp_pkg::PH_TAIL1:
                begin
                    push       = (in_byte == cfg.tail_second);
                    phase_next = gfp_pkg::PH_HEAD0;
                end
                default:
                begin
                    phase_next = gfp_pkg::PH_HEAD0;
                end
            endcase
        end
    end

    always_comb
    begin
        push_rec.id    = id_reg;
        push_rec.check = check_reg;
        push_rec.dec   = (len_reg == IDX_W'(PAYLOAD_MAX));
        for (int i = 0; i < gfp_pkg::UNPACK_BYTES; i++)
            push_rec.payload[(gfp_pkg::UNPACK_BYTES-1-i)*8 +: 8] = stage_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gfp_pkg::PH_HEAD0;
            idx_reg   <= '0;
            len_reg   <= '0;
            id_reg    <= '0;
            check_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            id_reg    <= id_next;
            check_reg <= check_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_we)
            stage_reg[idx_reg[gfp_pkg::SIDX_W-1:0]] <= in_byte;
    end

endmodule

@@ rtl/gfp_queue.sv @@
module gfp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gfp_pkg::rec_t push_rec,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output gfp_pkg::rec_t pop_rec
);

    localparam int QPTR_W = $clog2(gfp_pkg::QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(gfp_pkg::QUEUE_DEPTH + 1);

    gfp_pkg::rec_t     entry_reg [gfp_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(gfp_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign pop_rec = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    // depth is a power of two, pointers wrap on their own
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

@@ rtl/gfp_back.sv @@
module gfp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  gfp_pkg::rec_t pop_rec,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    packet_id,
    output logic [15:0]   check_word,
    output logic          decoded,
    output logic [63:0]   buttons_low,
    output logic [63:0]   buttons_high,
    output logic [15:0]   left_stick_x,
    output logic [15:0]   left_stick_y,
    output logic [15:0]   right_stick_x,
    output logic [15:0]   right_stick_y,
    output logic [31:0]   trigger_pair
);

    logic        out_valid_reg;
    logic [7:0]  id_reg;
    logic [15:0] check_reg;
    logic        dec_reg;
    logic [63:0] btn_lo_reg, btn_hi_reg;
    logic [15:0] lsx_reg, lsy_reg, rsx_reg, rsy_reg;
    logic [31:0] trig_reg;

    // controller state doubles as the result register, so only pop when it is free
    assign pop = q_valid && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            btn_lo_reg    <= '0;
            btn_hi_reg    <= '0;
            lsx_reg       <= '0;
            lsy_reg       <= '0;
            rsx_reg       <= '0;
            rsy_reg       <= '0;
            trig_reg      <= '0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            if (pop_rec.dec)
            begin
                btn_lo_reg <= pop_rec.payload[223:160];
                btn_hi_reg <= pop_rec.payload[159:96];
                lsx_reg    <= pop_rec.payload[95:80];
                lsy_reg    <= pop_rec.payload[79:64];
                rsx_reg    <= pop_rec.payload[63:48];
                rsy_reg    <= pop_rec.payload[47:32];
                trig_reg   <= pop_rec.payload[31:0];
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            id_reg    <= pop_rec.id;
            check_reg <= pop_rec.check;
            dec_reg   <= pop_rec.dec;
        end
    end

    assign out_valid     = out_valid_reg;
    assign packet_id     = id_reg;
    assign check_word    = check_reg;
    assign decoded       = dec_reg;
    assign buttons_low   = btn_lo_reg;
    assign buttons_high  = btn_hi_reg;
    assign left_stick_x  = lsx_reg;
    assign left_stick_y  = lsy_reg;
    assign right_stick_x = rsx_reg;
    assign right_stick_y = rsy_reg;
    assign trigger_pair  = trig_reg;

endmodule

@@ rtl/gamepad_frame_parser_core.sv @@
// gamepad frame parser
// input channel: in_valid/in_ready/in_byte, one stream byte per request
// frame layout: header, header, id, length, payload, check hi, check lo, tail, tail
// config channel: cfg_valid/cfg_ready/cfg_index/cfg_data, always ready, writes
//   header and tail match bytes (index 0..3), other indexes are ignored
// output channel: out_valid/out_ready and the result fields, one request per frame
//   whose two tail bytes match; decoded marks a full-length frame that refreshed
//   the stored buttons, sticks and triggers, which every result carries
// throughput: one byte per cycle while the frame queue is not full, set by the parse state machine
// result path: after the last tail byte is accepted the frame is written into the frame
//   queue, then moves into the result register once that register is free
// stall: a two-entry frame queue sits between parser and result register, so
//   bytes keep flowing while a result waits; in_ready drops only when the queue
//   is full, i.e. two more frames completed behind a held result
// reset: parser hunts for the first header, stored controller state is zero,
//   match bytes return to their defaults
module gamepad_frame_parser_core #(
    parameter int PAYLOAD_MAX = gfp_pkg::PAYLOAD_MAX_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gfp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      in_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      packet_id,
    output logic [15:0]                     check_word,
    output logic                            decoded,
    output logic [63:0]                     buttons_low,
    output logic [63:0]                     buttons_high,
    output logic [15:0]                     left_stick_x,
    output logic [15:0]                     left_stick_y,
    output logic [15:0]                     right_stick_x,
    output logic [15:0]                     right_stick_y,
    output logic [31:0]                     trigger_pair
);

    gfp_pkg::cfg_t cfg_reg, cfg_next;
    gfp_pkg::rec_t push_rec, pop_rec;
    logic          push, pop, q_full, q_valid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                gfp_pkg::REG_HEADER_FIRST:  cfg_next.header_first  = cfg_data;
                gfp_pkg::REG_HEADER_SECOND: cfg_next.header_second = cfg_data;
                gfp_pkg::REG_TAIL_FIRST:    cfg_next.tail_first    = cfg_data;
                gfp_pkg::REG_TAIL_SECOND:   cfg_next.tail_second   = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= gfp_pkg::HEADER_FIRST_RST;
            cfg_reg.header_second <= gfp_pkg::HEADER_SECOND_RST;
            cfg_reg.tail_first    <= gfp_pkg::TAIL_FIRST_RST;
            cfg_reg.tail_second   <= gfp_pkg::TAIL_SECOND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gfp_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .q_full   (q_full),
        .push     (push),
        .push_rec (push_rec)
    );

    gfp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_rec  (pop_rec)
    );

    gfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .pop_rec       (pop_rec),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .packet_id     (packet_id),
        .check_word    (check_word),
        .decoded       (decoded),
        .buttons_low   (buttons_low),
        .buttons_high  (buttons_high),
        .left_stick_x  (left_stick_x),
        .left_stick_y  (left_stick_y),
        .right_stick_x (right_stick_x),
        .right_stick_y (right_stick_y),
        .trigger_pair  (trigger_pair)
    );

endmodule

@@ rtl/gfp_checker.sv @@
`include "assert_macros.svh"

module gfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  packet_id,
    input logic [15:0] check_word
);

    // a held result keeps its payload
    `GFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                     out_valid && $stable(packet_id) && $stable(check_word))

    // a fresh result traces back to an earlier accepted input byte
    `GFP_ASSERT_IMPL(a_out_latency, clk, rst_n, $rose(out_valid),
                     $past(in_valid && in_ready, 2))

    // input backpressure only while a result waits at the output
    `GFP_ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_ready, out_valid)

    // config writes are never held off
    `GFP_ASSERT_IMPL(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind gamepad_frame_parser_core gfp_checker u_gfp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .packet_id  (packet_id),
    .check_word (check_word)
);

@@ tb/gamepad_frame_parser_core_tb.sv @@
`timescale 1ns / 100ps

module gamepad_frame_parser_core_tb;

    localparam int         FRAME_MAX    = gfp_pkg::PAYLOAD_MAX_DEF;
    localparam int         PIDX_W       = $clog2(FRAME_MAX);
    localparam logic [7:0] FULL_LEN     = 8'(FRAME_MAX);
    localparam int         DRAIN_CYCLES = 8;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         PHASE_BYTES  = 220;
    localparam int         PHASE_FRAMES = 8;

    localparam logic [7:0] HEADER_FIRST_RST  = gfp_pkg::HEADER_FIRST_RST;
    localparam logic [7:0] HEADER_SECOND_RST = gfp_pkg::HEADER_SECOND_RST;
    localparam logic [7:0] TAIL_FIRST_RST    = gfp_pkg::TAIL_FIRST_RST;
    localparam logic [7:0] TAIL_SECOND_RST   = gfp_pkg::TAIL_SECOND_RST;

    // index outside the register map, the block must ignore it
    localparam logic [gfp_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;

    typedef enum logic [1:0] {
        EXP_NONE,
        EXP_ZEROS,
        EXP_ONES
    } exp_kind_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] check;
        logic        dec;
        logic [63:0] btn_lo;
        logic [63:0] btn_hi;
        logic [15:0] lx;
        logic [15:0] ly;
        logic [15:0] rx;
        logic [15:0] ry;
        logic [31:0] trig;
    } frame_result_t;

    typedef struct packed {
        logic [7:0]  hd0;
        logic [7:0]  hd1;
        logic [7:0]  id;
        logic [7:0]  len;
        logic [7:0]  fill;
        logic [7:0]  step;
        logic [15:0] chk;
        logic [7:0]  tl0;
        logic [7:0]  tl1;
        logic [7:0]  nbytes;
        exp_kind_t   kind;
    } frame_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [gfp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]                      cfg_data;
    logic                            in_valid;
    logic                            in_ready;
    logic [7:0]                      in_byte;
    logic                            out_valid;
    logic                            out_ready = 1'b1;
    logic [7:0]                      packet_id;
    logic [15:0]                     check_word;
    logic                            decoded;
    logic [63:0]                     buttons_low;
    logic [63:0]                     buttons_high;
    logic [15:0]                     left_stick_x;
    logic [15:0]                     left_stick_y;
    logic [15:0]                     right_stick_x;
    logic [15:0]                     right_stick_y;
    logic [31:0]                     trigger_pair;

    gamepad_frame_parser_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_id    (packet_id),
        .check_word   (check_word),
        .decoded      (decoded),
        .buttons_low  (buttons_low),
        .buttons_high (buttons_high),
        .left_stick_x (left_stick_x),
        .left_stick_y (left_stick_y),
        .right_stick_x(right_stick_x),
        .right_stick_y(right_stick_y),
        .trigger_pair (trigger_pair)
    );

    // parser shadow state
    gfp_pkg::phase_t ph;
    logic [6:0]      pay_idx;
    logic [7:0]      cur_id;
    logic [7:0]      cur_len;
    logic [15:0]     cur_check;
    logic [7:0]      pay_bytes [FRAME_MAX];
    logic [7:0]      btn [16];
    logic [15:0]     axis [6];
    logic [7:0]      hdr0;
    logic [7:0]      hdr1;
    logic [7:0]      tl0;
    logic [7:0]      tl1;

    frame_result_t pending_frames [$];
    frame_result_t typed_result;
    bit            typed_valid;

    int send_gap_pct;
    int recv_stall_pct;
    int bytes_sent;
    int frames_expected;
    int mismatches;
    int idle_cycles;

    frame_row_t directed_rows [13] = '{
        // zero length after reset, one payload byte still consumed
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd0, EXP_ZEROS},
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'hFF, FULL_LEN, 8'hFF, 8'h00, 16'hFFFF,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd0, EXP_ONES},
        // short frame keeps the stored controller state
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h5A, FULL_LEN - 8'd1, 8'h3C, 8'h01,
          16'h1234, TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd0, EXP_ONES},
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h00, FULL_LEN, 8'h00, 8'h00, 16'h0000,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd0, EXP_ZEROS},
        // oversize length drops the frame right after the length byte
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h11, FULL_LEN + 8'd1, 8'h00, 8'h00,
          16'h0000, TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd4, EXP_NONE},
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h22, 8'hFF, 8'h00, 8'h00, 16'h0000,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd4, EXP_NONE},
        '{HEADER_FIRST_RST, 8'h00, 8'h33, 8'h05, 8'h00, 8'h00, 16'h0000,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd2, EXP_NONE},
        // bad second header equal to the first header must not be taken as a new first header
        '{HEADER_FIRST_RST, HEADER_FIRST_RST, 8'h99, 8'h05, 8'h00, 8'h00, 16'h0000,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd2, EXP_NONE},
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h44, 8'h03, 8'h10, 8'h01, 16'hBEEF,
          8'h00, TAIL_SECOND_RST, 8'd10, EXP_NONE},
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h55, 8'h03, 8'h20, 8'h01, 16'hCAFE,
          TAIL_FIRST_RST, 8'h00, 8'd0, EXP_NONE},
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h66, FULL_LEN, 8'h01, 8'h01, 16'hA55A,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd0, EXP_NONE},
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h77, FULL_LEN, 8'h80, 8'h07, 16'h5AA5,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd0, EXP_NONE},
        '{HEADER_FIRST_RST, HEADER_SECOND_RST, 8'h88, 8'h01, 8'hFE, 8'h00, 16'hFFFF,
          TAIL_FIRST_RST, TAIL_SECOND_RST, 8'd0, EXP_NONE}
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic clear_frame();
        ph        = gfp_pkg::PH_HEAD0;
        pay_idx   = '0;
        cur_id    = '0;
        cur_len   = '0;
        cur_check = '0;
        foreach (pay_bytes[i])
            pay_bytes[i] = '0;
    endtask

    // advances the shadow parser by one byte, queues the frame result it completes
    task automatic parse_byte(input logic [7:0] b);
        frame_result_t r;
        case (ph)
            gfp_pkg::PH_HEAD0:
                if (b == hdr0)
                    ph = gfp_pkg::PH_HEAD1;
            gfp_pkg::PH_HEAD1:
                ph = (b == hdr1) ? gfp_pkg::PH_ID : gfp_pkg::PH_HEAD0;
            gfp_pkg::PH_ID:
            begin
                cur_id = b;
                ph     = gfp_pkg::PH_LEN;
            end
            gfp_pkg::PH_LEN:
            begin
                cur_len = b;
                if (b > FULL_LEN)
                    clear_frame();
                else
                begin
                    pay_idx = '0;
                    ph      = gfp_pkg::PH_DATA;
                end
            end
            gfp_pkg::PH_DATA:
            begin
                if (pay_idx < FRAME_MAX)
                    pay_bytes[pay_idx[PIDX_W-1:0]] = b;
                pay_idx = pay_idx + 7'd1;
                if ({1'b0, pay_idx} >= cur_len)
                    ph = gfp_pkg::PH_CHK0;
            end
            gfp_pkg::PH_CHK0:
            begin
                cur_check[15:8] = b;
                ph = gfp_pkg::PH_CHK1;
            end
            gfp_pkg::PH_CHK1:
            begin
                cur_check[7:0] = b;
                ph = gfp_pkg::PH_TAIL0;
            end
            gfp_pkg::PH_TAIL0:
                ph = (b == tl0) ? gfp_pkg::PH_TAIL1 : gfp_pkg::PH_HEAD0;
            gfp_pkg::PH_TAIL1:
            begin
                if (b != tl1)
                    ph = gfp_pkg::PH_HEAD0;
                else
                begin
                    r       = '0;
                    r.id    = cur_id;
                    r.check = cur_check;
                    r.dec   = (cur_len == FULL_LEN);
                    if (r.dec)
                    begin
                        for (int i = 0; i < 16; i++)
                            btn[i] = pay_bytes[i];
                        for (int i = 0; i < 6; i++)
                            axis[i] = {pay_bytes[16 + 2 * i], pay_bytes[17 + 2 * i]};
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        r.btn_lo = {r.btn_lo[55:0], btn[i]};
                        r.btn_hi = {r.btn_hi[55:0], btn[8 + i]};
                    end
                    r.lx   = axis[0];
                    r.ly   = axis[1];
                    r.rx   = axis[2];
                    r.ry   = axis[3];
                    r.trig = {axis[4], axis[5]};
                    if (typed_valid)
                        r = typed_result;
                    typed_valid = 1'b0;
                    pending_frames.push_back(r);
                    frames_expected++;
                    clear_frame();
                end
            end
            default:
                clear_frame();
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%s mismatch: expected %h, got %h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: packet_id %h", packet_id);
            end
            else
            begin
                want = pending_frames.pop_front();
                check_field("packet_id", want.id, packet_id);
                check_field("check_word", want.check, check_word);
                check_field("decoded", want.dec, decoded);
                check_field("buttons_low", want.btn_lo, buttons_low);
                check_field("buttons_high", want.btn_hi, buttons_high);
                check_field("left_stick_x", want.lx, left_stick_x);
                check_field("left_stick_y", want.ly, left_stick_y);
                check_field("right_stick_x", want.rx, right_stick_x);
                check_field("right_stick_y", want.ry, right_stick_y);
                check_field("trigger_pair", want.trig, trigger_pair);
            end
        end
    end

    // cycles without any accepted request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_gap_pct);
        end
        in_valid = 1'b1;
        in_byte  = b;
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // nbytes of zero sends the whole frame, otherwise only its first nbytes
    task automatic send_frame(input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] id,
                              input logic [7:0] len, input logic [7:0] fill,
                              input logic [7:0] step, input logic [15:0] chk,
                              input logic [7:0] t0, input logic [7:0] t1,
                              input logic [7:0] nbytes, input bit rnd);
        logic [7:0] frame_bytes [$];
        int         data_cnt;
        int         n;
        data_cnt = (len > FULL_LEN) ? 0 : ((len == 0) ? 1 : int'(len));
        frame_bytes = '{h0, h1, id, len};
        for (int i = 0; i < data_cnt; i++)
            frame_bytes.push_back(rnd ? 8'($urandom) : 8'(fill + step * i));
        frame_bytes.push_back(chk[15:8]);
        frame_bytes.push_back(chk[7:0]);
        frame_bytes.push_back(t0);
        frame_bytes.push_back(t1);
        n = (nbytes == 0) ? frame_bytes.size() : int'(nbytes);
        for (int i = 0; i < n; i++)
            send_byte(frame_bytes[i]);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [gfp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            gfp_pkg::REG_HEADER_FIRST:  hdr0 = val;
            gfp_pkg::REG_HEADER_SECOND: hdr1 = val;
            gfp_pkg::REG_TAIL_FIRST:    tl0  = val;
            gfp_pkg::REG_TAIL_SECOND:   tl1  = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] h0, input logic [7:0] h1,
                             input logic [7:0] t0, input logic [7:0] t1);
        wait_drained();
        write_reg(gfp_pkg::REG_HEADER_FIRST, h0);
        write_reg(gfp_pkg::REG_HEADER_SECOND, h1);
        write_reg(gfp_pkg::REG_TAIL_FIRST, t0);
        write_reg(gfp_pkg::REG_TAIL_SECOND, t1);
        write_reg(REG_UNUSED, 8'($urandom));
        cfg_valid = 1'b0;
    endtask

    function automatic logic [7:0] other_than(input logic [7:0] v);
        return v ^ 8'($urandom_range(255, 1));
    endfunction

    // mostly well-formed frames, the rest noise and broken frames
    task automatic run_traffic();
        int         start_bytes;
        int         start_frames;
        int         kind;
        logic [7:0] len;
        start_bytes  = bytes_sent;
        start_frames = frames_expected;
        while (bytes_sent - start_bytes < PHASE_BYTES ||
               frames_expected - start_frames < PHASE_FRAMES)
        begin
            kind = $urandom_range(99);
            len  = ($urandom_range(2) == 0) ? FULL_LEN : 8'($urandom_range(FRAME_MAX));
            if (kind < 75)
                send_frame(hdr0, hdr1, 8'($urandom), len, 8'h00, 8'h00, 16'($urandom),
                           tl0, tl1, 8'd0, 1'b1);
            else if (kind < 80)
                repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
            else if (kind < 85)
                send_frame(hdr0, hdr1, 8'($urandom), 8'($urandom_range(255, FRAME_MAX + 1)),
                           8'h00, 8'h00, 16'($urandom), tl0, tl1, 8'd4, 1'b1);
            else if (kind < 90)
                send_frame(hdr0, other_than(hdr1), 8'($urandom), len, 8'h00, 8'h00,
                           16'($urandom), tl0, tl1, 8'd2, 1'b1);
            else if (kind < 95)
                send_frame(hdr0, hdr1, 8'($urandom), len, 8'h00, 8'h00, 16'($urandom),
                           other_than(tl0), tl1, 8'(7 + ((len == 0) ? 1 : len)), 1'b1);
            else
                send_frame(hdr0, hdr1, 8'($urandom), len, 8'h00, 8'h00, 16'($urandom),
                           tl0, other_than(tl1), 8'd0, 1'b1);
            if ($urandom_range(99) < 3)
                wait_drained();
        end
    endtask

    initial
    begin : stimulus
        frame_row_t row;
        logic [7:0] fb;
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        in_byte         = '0;
        send_gap_pct    = 29;
        recv_stall_pct  = 59;
        bytes_sent      = 0;
        frames_expected = 0;
        mismatches      = 0;
        idle_cycles     = 0;
        typed_valid     = 1'b0;
        hdr0 = HEADER_FIRST_RST;
        hdr1 = HEADER_SECOND_RST;
        tl0  = TAIL_FIRST_RST;
        tl1  = TAIL_SECOND_RST;
        clear_frame();
        foreach (btn[i])
            btn[i] = '0;
        foreach (axis[i])
            axis[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            typed_valid = (row.kind != EXP_NONE);
            if (typed_valid)
            begin
                fb = (row.kind == EXP_ONES) ? 8'hFF : 8'h00;
                typed_result = '{id: row.id, check: row.chk, dec: (row.len == FULL_LEN),
                                 btn_lo: {8{fb}}, btn_hi: {8{fb}}, lx: {2{fb}},
                                 ly: {2{fb}}, rx: {2{fb}}, ry: {2{fb}}, trig: {4{fb}}};
            end
            send_frame(row.hd0, row.hd1, row.id, row.len, row.fill, row.step, row.chk,
                       row.tl0, row.tl1, row.nbytes, 1'b0);
        end

        configure(8'h00, 8'hFF, 8'hFF, 8'h00);
        run_traffic();

        send_gap_pct   = 59;
        recv_stall_pct = 29;
        configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_traffic();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        configure(8'hFF, 8'h00, 8'h00, 8'hFF);
        run_traffic();

        in_valid = 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_frames.size() != 0)
        begin
            mismatches++;
            $display("%0d results never arrived", pending_frames.size());
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
